[design/ilnr_pkg.sv]
// Shared constants and types of the integer layer-norm requantiser.
// Depends on nothing; used by every other file of the block.
package ilnr_pkg;

  // Row store and index widths
  localparam int ROW_CAP = 1024;
  localparam int ADDR_W  = $clog2(ROW_CAP);
  localparam int LEN_W   = ADDR_W + 1;

  // Fixed-point scale format (unsigned Q8.SCALE_FRAC)
  localparam int SCALE_FRAC = 24;

  // Field widths fixed by the item format
  localparam int DATA_W   = 16;
  localparam int RLEN_W   = 11;
  localparam int SCALE_W  = 32;
  localparam int STDEV_W  = 9;
  localparam int ROOT_W   = 8;
  localparam int SUM_W    = 32;
  localparam int OUT_W    = 8;

  // Shared divider geometry
  localparam int DVD_W = 32;
  localparam int DVS_W = (LEN_W > STDEV_W) ? LEN_W : STDEV_W;
  localparam int CNT_W = $clog2(DVD_W);

  // Configuration register indexes
  localparam logic [1:0] REG_ROW_LENGTH   = 2'd0;
  localparam logic [1:0] REG_EPS_TERM     = 2'd1;
  localparam logic [1:0] REG_SCALE_FACTOR = 2'd2;
  localparam logic [1:0] REG_OUT_SCALE    = 2'd3;

  // Operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic               start;
    logic [DVD_W-1:0]   dividend;
    logic [DVS_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DVD_W-1:0]   quotient;
  } div_rsp_t;

endpackage

[design/ilnr_if.sv]
// Valid/ready channel interfaces for input and result items.
// Depends on ilnr_pkg for field widths.
interface ilnr_in_if;
  logic                               valid;
  logic                               ready;
  logic                               operation;
  logic signed [ilnr_pkg::DATA_W-1:0] act_value;
  logic signed [ilnr_pkg::DATA_W-1:0] gamma;
  logic signed [ilnr_pkg::DATA_W-1:0] beta;

  modport source (output valid, operation, act_value, gamma, beta, input ready);
  modport sink   (input valid, operation, act_value, gamma, beta, output ready);
endinterface

interface ilnr_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [ilnr_pkg::OUT_W-1:0] norm_out;
  logic                              last;
  logic                              status;

  modport source (output valid, norm_out, last, status, input ready);
  modport sink   (input valid, norm_out, last, status, output ready);
endinterface

[design/integer_layernorm_requant_unit.sv]
// Top level of the integer layer-norm requantiser: control sequencer,
// configuration registers, row statistics and the read datapath.
// Depends on ilnr_pkg, ilnr_if, ilnr_row_mem and ilnr_div.
//
// Usage: in_ch carries items; operation 0 stores act_value as the next row
// element and gives no result, operation 1 returns one normalised int8
// element on out_ch (gamma and beta apply to that element). A read with no
// completed row returns status 1. Configuration is to be written through
// cfg_wr_en/cfg_index/cfg_data only while the block is idle; the block
// itself does not enforce this. A load stores its element or, when it
// completes the row, starts the row statistics: the mean, the variance
// walk over the elements (each term through the shared 32-step divider)
// and the square root (giving 1 when the variance is not positive). A read
// goes through the divider and the scaling steps, then its result waits
// in the output register.
// Reset clears all control state; the row store is not cleared. When the
// receiver stalls, the result is held in the output register and the next
// input item is taken; a second result waits until the register frees.
module integer_layernorm_requant_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [1:0]                    cfg_index,
  input  logic [ilnr_pkg::SCALE_W-1:0]  cfg_data,
  ilnr_in_if.sink                       in_ch,
  ilnr_out_if.source                    out_ch
);

  typedef enum logic [3:0] {
    S_IDLE, S_MEAN, S_MEAN_WAIT, S_VAR_RD, S_VAR_DATA, S_VAR_DIV, S_VAR_WAIT,
    S_SQRT, S_RD_DATA, S_RD_WAIT, S_RD_MUL, S_RD_SC1, S_RD_SC2, S_RD_SAT, S_OUT
  } state_t;

  // Configuration registers
  logic [ilnr_pkg::RLEN_W-1:0]         row_length;
  logic signed [ilnr_pkg::DATA_W-1:0]  eps_term;
  logic [ilnr_pkg::SCALE_W-1:0]        scale_factor;
  logic [ilnr_pkg::SCALE_W-1:0]        out_scale;

  state_t                              state;
  logic [ilnr_pkg::ADDR_W-1:0]         write_index;
  logic [ilnr_pkg::ADDR_W-1:0]         read_index;
  logic [ilnr_pkg::ADDR_W-1:0]         walk_index;
  logic                                row_ready;
  logic signed [ilnr_pkg::SUM_W-1:0]   running_sum;
  logic signed [ilnr_pkg::DATA_W-1:0]  row_mean;
  logic [ilnr_pkg::STDEV_W-1:0]        row_stdev;
  logic [ilnr_pkg::DATA_W-1:0]         var_acc;
  logic [ilnr_pkg::ROOT_W-1:0]         root;
  logic [ilnr_pkg::ROOT_W-1:0]         root_mask;
  logic                                sum_neg;
  logic [ilnr_pkg::DVD_W-1:0]          sq;
  logic signed [ilnr_pkg::DATA_W-1:0]  rd_gamma;
  logic signed [ilnr_pkg::DATA_W-1:0]  rd_beta;
  logic                                rd_last;
  logic                                d_neg;
  logic signed [ilnr_pkg::DATA_W-1:0]  q;
  logic signed [ilnr_pkg::SUM_W-1:0]   t;
  logic [2*ilnr_pkg::SCALE_W-1:0]      prod1;
  logic [ilnr_pkg::DATA_W+ilnr_pkg::SCALE_W-1:0] prod2;
  logic                                t_neg;
  logic signed [ilnr_pkg::OUT_W-1:0]   r_norm;
  logic                                r_status;
  logic                                out_valid;
  logic signed [ilnr_pkg::OUT_W-1:0]   out_norm;
  logic                                out_last;
  logic                                out_status;

  logic [ilnr_pkg::LEN_W-1:0]          eff_len;
  logic                                accept;
  logic                                out_load;
  logic                                mem_we;
  logic [ilnr_pkg::ADDR_W-1:0]         mem_raddr;
  logic [ilnr_pkg::DATA_W-1:0]         mem_rdata;
  logic signed [ilnr_pkg::DATA_W-1:0]  d_cur;
  logic signed [ilnr_pkg::DATA_W-1:0]  act_x;
  logic [ilnr_pkg::ROOT_W-1:0]         trial;
  logic [2*ilnr_pkg::ROOT_W-1:0]       trial_sq;
  logic signed [ilnr_pkg::DATA_W:0]    var_sum;
  logic [ilnr_pkg::SUM_W-1:0]          t_mag;
  logic [ilnr_pkg::SUM_W-1:0]          sum_mag;
  logic [2*ilnr_pkg::SCALE_W-1:0]      p1;
  logic [ilnr_pkg::DATA_W+ilnr_pkg::SCALE_W-1:0] p2;
  logic signed [ilnr_pkg::DATA_W-1:0]  a_sat;
  logic [ilnr_pkg::DATA_W-1:0]         a_mag;
  logic signed [ilnr_pkg::OUT_W-1:0]   o_sat;
  logic signed [ilnr_pkg::DATA_W-1:0]  q_res;
  ilnr_pkg::div_req_t                  div_req;
  ilnr_pkg::div_rsp_t                  div_rsp;

  // Clamp the row length into 1..capacity
  always_comb begin
    if (row_length == '0) begin
      eff_len = ilnr_pkg::LEN_W'(1);
    end else if (32'(row_length) > ilnr_pkg::ROW_CAP) begin
      eff_len = ilnr_pkg::LEN_W'(ilnr_pkg::ROW_CAP);
    end else begin
      eff_len = ilnr_pkg::LEN_W'(row_length);
    end
  end

  assign accept    = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == S_IDLE);
  assign out_load  = (state == S_OUT) && (!out_valid || out_ch.ready);
  assign act_x     = in_ch.act_value;
  assign mem_we    = accept && (in_ch.operation == ilnr_pkg::OP_LOAD);
  assign mem_raddr = (state == S_IDLE) ? read_index : walk_index;
  assign d_cur     = $signed(mem_rdata) - row_mean;

  ilnr_row_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (write_index),
    .wdata (act_x),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ilnr_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Divider requests for the mean, the variance terms and d/stdev
  always_comb begin
    sum_mag = running_sum[ilnr_pkg::SUM_W-1] ? ilnr_pkg::SUM_W'(-running_sum)
                                             : ilnr_pkg::SUM_W'(running_sum);
    div_req.start    = 1'b0;
    div_req.dividend = sum_mag;
    div_req.divisor  = ilnr_pkg::DVS_W'(eff_len);
    case (state)
      S_MEAN: begin
        div_req.start = 1'b1;
      end
      S_VAR_DIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = sq;
      end
      S_RD_DATA: begin
        div_req.start    = 1'b1;
        div_req.dividend = ilnr_pkg::DVD_W'(d_cur[ilnr_pkg::DATA_W-1] ?
                             ilnr_pkg::DATA_W'(-d_cur) : d_cur);
        div_req.divisor  = ilnr_pkg::DVS_W'(row_stdev);
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  // Square root trial, variance plus epsilon
  always_comb begin
    trial    = root | root_mask;
    trial_sq = trial * trial;
    var_sum  = $signed({var_acc[ilnr_pkg::DATA_W-1], var_acc}) +
               $signed({eps_term[ilnr_pkg::DATA_W-1], eps_term});
  end

  // Read datapath arithmetic: quotient sign, magnitudes, saturation
  always_comb begin
    q_res = d_neg ? ilnr_pkg::DATA_W'(-div_rsp.quotient[ilnr_pkg::DATA_W-1:0])
                  : div_rsp.quotient[ilnr_pkg::DATA_W-1:0];
    t_mag = t[ilnr_pkg::SUM_W-1] ? ilnr_pkg::SUM_W'(-t) : ilnr_pkg::SUM_W'(t);
    p1    = prod1 >> ilnr_pkg::SCALE_FRAC;
    if (t_neg) begin
      a_sat = (p1 > 64'd32768) ? -16'sd32768 : ilnr_pkg::DATA_W'(-p1[15:0]);
    end else begin
      a_sat = (p1 > 64'd32767) ? 16'sd32767 : ilnr_pkg::DATA_W'(p1[15:0]);
    end
    a_mag = a_sat[ilnr_pkg::DATA_W-1] ? ilnr_pkg::DATA_W'(-a_sat) : a_sat;
    p2    = prod2 >> ilnr_pkg::SCALE_FRAC;
    if (t_neg) begin
      o_sat = (p2 > 48'd128) ? -8'sd128 : ilnr_pkg::OUT_W'(-p2[7:0]);
    end else begin
      o_sat = (p2 > 48'd127) ? 8'sd127 : ilnr_pkg::OUT_W'(p2[7:0]);
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      row_length   <= ilnr_pkg::RLEN_W'(768);
      eps_term     <= '0;
      scale_factor <= ilnr_pkg::SCALE_W'(32'h0100_0000);
      out_scale    <= ilnr_pkg::SCALE_W'(32'h0100_0000);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        ilnr_pkg::REG_ROW_LENGTH:   row_length   <= cfg_data[ilnr_pkg::RLEN_W-1:0];
        ilnr_pkg::REG_EPS_TERM:     eps_term     <= cfg_data[ilnr_pkg::DATA_W-1:0];
        ilnr_pkg::REG_SCALE_FACTOR: scale_factor <= cfg_data;
        ilnr_pkg::REG_OUT_SCALE:    out_scale    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer with its registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      write_index <= '0;
      read_index  <= '0;
      walk_index  <= '0;
      row_ready   <= 1'b0;
      running_sum <= '0;
      row_mean    <= '0;
      row_stdev   <= ilnr_pkg::STDEV_W'(1);
      out_valid   <= 1'b0;
    end else begin
      // Load the output register, or drop the result once taken
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (in_ch.operation == ilnr_pkg::OP_LOAD) begin
              row_ready   <= 1'b0;
              read_index  <= '0;
              running_sum <= running_sum + ilnr_pkg::SUM_W'(act_x);
              if ({1'b0, write_index} + 1'b1 >= eff_len) begin
                state <= S_MEAN;
              end else begin
                write_index <= write_index + 1'b1;
              end
            end else if (!row_ready) begin
              r_norm   <= '0;
              rd_last  <= 1'b0;
              r_status <= 1'b1;
              state    <= S_OUT;
            end else begin
              rd_gamma <= in_ch.gamma;
              rd_beta  <= in_ch.beta;
              r_status <= 1'b0;
              if ({1'b0, read_index} + 1'b1 >= eff_len) begin
                rd_last    <= 1'b1;
                read_index <= '0;
                row_ready  <= 1'b0;
              end else begin
                rd_last    <= 1'b0;
                read_index <= read_index + 1'b1;
              end
              state <= S_RD_DATA;
            end
          end
        end
        S_MEAN: begin
          sum_neg <= running_sum[ilnr_pkg::SUM_W-1];
          state   <= S_MEAN_WAIT;
        end
        S_MEAN_WAIT: begin
          if (div_rsp.done) begin
            row_mean   <= sum_neg ?
                          ilnr_pkg::DATA_W'(-div_rsp.quotient[ilnr_pkg::DATA_W-1:0])
                        : div_rsp.quotient[ilnr_pkg::DATA_W-1:0];
            walk_index <= '0;
            var_acc    <= '0;
            state      <= S_VAR_RD;
          end
        end
        S_VAR_RD: begin
          state <= S_VAR_DATA;
        end
        S_VAR_DATA: begin
          sq    <= ilnr_pkg::DVD_W'(d_cur * d_cur);
          state <= S_VAR_DIV;
        end
        S_VAR_DIV: begin
          state <= S_VAR_WAIT;
        end
        S_VAR_WAIT: begin
          if (div_rsp.done) begin
            var_acc <= var_acc + div_rsp.quotient[ilnr_pkg::DATA_W-1:0];
            if ({1'b0, walk_index} + 1'b1 >= eff_len) begin
              root      <= '0;
              root_mask <= {1'b1, {(ilnr_pkg::ROOT_W-1){1'b0}}};
              state     <= S_SQRT;
            end else begin
              walk_index <= walk_index + 1'b1;
              state      <= S_VAR_RD;
            end
          end
        end
        S_SQRT: begin
          // One root bit per cycle; a non-positive variance gives 1
          if (var_sum <= 0) begin
            row_stdev <= ilnr_pkg::STDEV_W'(1);
          end else begin
            if (trial_sq <= var_sum[ilnr_pkg::DATA_W-1:0]) begin
              root <= trial;
            end
            root_mask <= root_mask >> 1;
            if (root_mask == ilnr_pkg::ROOT_W'(1)) begin
              if (trial_sq <= var_sum[ilnr_pkg::DATA_W-1:0]) begin
                row_stdev <= ilnr_pkg::STDEV_W'(trial);
              end else if (root == '0) begin
                row_stdev <= ilnr_pkg::STDEV_W'(1);
              end else begin
                row_stdev <= ilnr_pkg::STDEV_W'(root);
              end
            end
          end
          if (var_sum <= 0 || root_mask == ilnr_pkg::ROOT_W'(1)) begin
            running_sum <= '0;
            write_index <= '0;
            read_index  <= '0;
            row_ready   <= 1'b1;
            state       <= S_IDLE;
          end
        end
        S_RD_DATA: begin
          d_neg <= d_cur[ilnr_pkg::DATA_W-1];
          state <= S_RD_WAIT;
        end
        S_RD_WAIT: begin
          if (div_rsp.done) begin
            q     <= q_res;
            state <= S_RD_MUL;
          end
        end
        S_RD_MUL: begin
          t     <= ilnr_pkg::SUM_W'(q * rd_gamma) + ilnr_pkg::SUM_W'(rd_beta);
          state <= S_RD_SC1;
        end
        S_RD_SC1: begin
          t_neg <= t[ilnr_pkg::SUM_W-1];
          prod1 <= t_mag * scale_factor;
          state <= S_RD_SC2;
        end
        S_RD_SC2: begin
          prod2 <= a_mag * out_scale;
          state <= S_RD_SAT;
        end
        S_RD_SAT: begin
          r_norm <= o_sat;
          state  <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            out_norm   <= r_norm;
            out_last   <= rd_last;
            out_status <= r_status;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid    = out_valid;
  assign out_ch.norm_out = out_norm;
  assign out_ch.last     = out_last;
  assign out_ch.status   = out_status;

endmodule

[design/ilnr_row_mem.sv]
// Row store: one write port, one read port with registered read data.
// Depends on ilnr_pkg for depth and width.
module ilnr_row_mem (
  input  logic                               clk,
  input  logic                               we,
  input  logic [ilnr_pkg::ADDR_W-1:0]        waddr,
  input  logic [ilnr_pkg::DATA_W-1:0]        wdata,
  input  logic [ilnr_pkg::ADDR_W-1:0]        raddr,
  output logic [ilnr_pkg::DATA_W-1:0]        rdata
);

  logic [ilnr_pkg::DATA_W-1:0] mem [ilnr_pkg::ROW_CAP];

  // Write when enabled; read every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/ilnr_div.sv]
// Shared unsigned restoring divider, one quotient bit per cycle.
// Depends on ilnr_pkg for widths and the request/response structs.
module ilnr_div (
  input  logic                 clk,
  input  logic                 rst,
  input  ilnr_pkg::div_req_t   req,
  output ilnr_pkg::div_rsp_t   rsp
);

  logic                           busy;
  logic                           done;
  logic [ilnr_pkg::CNT_W-1:0]     cnt;
  logic [ilnr_pkg::DVD_W-1:0]     quo;
  logic [ilnr_pkg::DVS_W:0]       rem;
  logic [ilnr_pkg::DVS_W-1:0]     dvs;
  logic [ilnr_pkg::DVS_W:0]       rem_sh;
  logic [ilnr_pkg::DVS_W:0]       rem_next;
  logic                           take;

  // Shift in the next dividend bit and try a subtract
  always_comb begin
    rem_sh   = {rem[ilnr_pkg::DVS_W-1:0], quo[ilnr_pkg::DVD_W-1]};
    take     = rem_sh >= {1'b0, dvs};
    rem_next = take ? rem_sh - {1'b0, dvs} : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (busy) begin
        rem <= rem_next;
        quo <= {quo[ilnr_pkg::DVD_W-2:0], take};
        cnt <= cnt + 1'b1;
        if (cnt == ilnr_pkg::CNT_W'(ilnr_pkg::DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= req.dividend;
        dvs  <= req.divisor;
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule
